// File: rtl/order_reference_tracker_defines.svh
// ----------------------------------------------------------------------------
// Order reference tracker assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORDER_REFERENCE_TRACKER_DEFINES_SVH
`define ORDER_REFERENCE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define ORT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every clock edge, reset included
`define ORT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ORT_ASSERT(lbl, prop, msg)
`define ORT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/ort_pkg.sv
// ----------------------------------------------------------------------------
// Order reference tracker package
// Table geometry, message and result codes, and shared types.
// ----------------------------------------------------------------------------
package ort_pkg;

  // table geometry; depth is a power of two so the probe window wraps by masking
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned MAX_PROBES  = 8;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned PRB_W       = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

  // golden-ratio multiplier of the reference hash, in 32-bit halves
  localparam logic [31:0] HASH_MULT_LO = 32'h7F4A7C15;
  localparam logic [31:0] HASH_MULT_HI = 32'h9E3779B9;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REDUCE  = 2'd1,
    OP_DELETE  = 2'd2,
    OP_REPLACE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_status_e;

  // one stored order
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] price;
    logic [31:0] shares;
    logic [15:0] instrument;
    logic        side;
  } entry_t;

  // table access for one cycle
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             st_we;
    slot_status_e     st_wdata;
    logic             ent_we;
    entry_t           ent_wdata;
  } tbl_req_t;

  // one book command
  typedef struct packed {
    kind_e       kind;
    logic [15:0] book_index;
    logic [31:0] price;
    logic [31:0] shares;
    logic        side;
    logic        overflow;
    logic        last;
  } result_t;

endpackage

// File: rtl/ort_hash.sv
// ----------------------------------------------------------------------------
// Order reference hash unit
// Home slot of a 64-bit key from one shared 32x32 multiplier over three steps.
// ----------------------------------------------------------------------------
module ort_hash (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [63:0]             key_i,
  output logic                    done_o,
  output logic [ort_pkg::IDX_W-1:0] home_o
);

  logic [2:0]  step_q;
  logic [63:0] key_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [31:0] op_a;
  logic [31:0] op_b;

  // operand select: lo*lo, lo*hi, hi*lo (only the low 64 product bits matter)
  always_comb begin
    case (step_q)
      3'd1: begin
        op_a = key_q[31:0];
        op_b = ort_pkg::HASH_MULT_LO;
      end
      3'd2: begin
        op_a = key_q[31:0];
        op_b = ort_pkg::HASH_MULT_HI;
      end
      3'd3: begin
        op_a = key_q[63:32];
        op_b = ort_pkg::HASH_MULT_LO;
      end
      default: begin
        op_a = key_q[31:0];
        op_b = ort_pkg::HASH_MULT_LO;
      end
    endcase
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
    end else if (start_i) begin
      step_q <= 3'd1;
    end else if (step_q == 3'd5) begin
      step_q <= 3'd0;
    end else if (step_q != 3'd0) begin
      step_q <= step_q + 3'd1;
    end
  end

  // multiplier and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    prod_q <= 64'(op_a) * 64'(op_b);
    case (step_q)
      3'd2:         acc_q <= prod_q;
      3'd3, 3'd4:   acc_q <= acc_q + {prod_q[31:0], 32'h0};
      default:      acc_q <= acc_q;
    endcase
  end

  assign done_o = (step_q == 3'd5);
  // (h ^ (h >> 29)) mod depth
  assign home_o = acc_q[ort_pkg::IDX_W-1:0] ^ acc_q[ort_pkg::IDX_W+28:29];

endmodule

// File: rtl/ort_table.sv
// ----------------------------------------------------------------------------
// Order reference table storage
// Slot status and order entry memories, one write and one registered read.
// ----------------------------------------------------------------------------
module ort_table (
  input  logic                   clk_i,
  input  ort_pkg::tbl_req_t      req_i,
  output ort_pkg::slot_status_e  rd_status_o,
  output ort_pkg::entry_t        rd_entry_o
);

  ort_pkg::slot_status_e status_mem [ort_pkg::TABLE_DEPTH];
  ort_pkg::entry_t       entry_mem  [ort_pkg::TABLE_DEPTH];

  // status memory
  always_ff @(posedge clk_i) begin
    if (req_i.st_we) begin
      status_mem[req_i.wr_addr] <= req_i.st_wdata;
    end
    rd_status_o <= status_mem[req_i.rd_addr];
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (req_i.ent_we) begin
      entry_mem[req_i.wr_addr] <= req_i.ent_wdata;
    end
    rd_entry_o <= entry_mem[req_i.rd_addr];
  end

endmodule

// File: rtl/order_reference_tracker.sv
// ----------------------------------------------------------------------------
// Order reference tracker
// Live-order table keyed by 64-bit reference, emitting book level commands.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with one port per message field.
// Output channel: out_valid_o / out_stall_i, one book command per transaction;
// last_o marks the final command of a message (a replace of a found order gives two).
// One message at a time: in_stall_o stays high from acceptance until the final
// command has been loaded into the output register.
// Per lookup pass: the key is hashed in the shared multiplier of ort_hash,
// then each probed slot gets a registered memory read then a check, up to
// MAX_PROBES slots, then one update and the load of the output register.
// The next message can be accepted once the final command is loaded; a
// replace of a found order runs two passes, one for the remove and one for
// the add. After reset a clearing pass marks every slot empty, one slot a
// cycle, for all TABLE_DEPTH (4096) slots; in_stall_o is high throughout.
// When the receiver stalls, the command waits in the output register and the
// sequencer holds until it can load the next one.
// ----------------------------------------------------------------------------
`include "order_reference_tracker_defines.svh"

module order_reference_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] order_ref_i,
  input  logic [63:0] new_ref_i,
  input  logic [31:0] price_i,
  input  logic [31:0] quantity_i,
  input  logic [15:0] instrument_i,
  input  logic        side_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] book_index_o,
  output logic [31:0] level_price_o,
  output logic [31:0] level_shares_o,
  output logic        side_out_o,
  output logic        overflow_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = ort_pkg::IDX_W;
  localparam int unsigned PRB_W = ort_pkg::PRB_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_CHK   = 7'b0010000,
    S_ACT   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        clr_cnt_q;
  ort_pkg::opcode_e        op_q;
  logic                    pass_q;
  logic [63:0]             key_q;
  logic [63:0]             nref_q;
  logic [31:0]             price_q;
  logic [31:0]             qty_q;
  logic [15:0]             ins_inst_q;
  logic                    ins_side_q;
  logic [IDX_W-1:0]        base_q;
  logic [PRB_W-1:0]        probe_q;
  logic                    hit_q;
  logic [IDX_W-1:0]        hit_slot_q;
  ort_pkg::entry_t         hit_ent_q;
  logic                    free_vld_q;
  logic [IDX_W-1:0]        free_slot_q;
  ort_pkg::result_t        pend_q;
  ort_pkg::result_t        out_q;
  logic                    out_valid_q;

  logic                    in_acc;
  logic                    out_free;
  logic                    hash_start;
  logic [63:0]             hash_key;
  logic                    hash_done;
  logic [IDX_W-1:0]        hash_home;
  logic [IDX_W-1:0]        slot_cur;
  ort_pkg::tbl_req_t       tbl_req;
  ort_pkg::slot_status_e   rd_status;
  ort_pkg::entry_t         rd_entry;
  logic                    ins_mode;
  logic                    tgt_vld;
  logic [IDX_W-1:0]        tgt_slot;
  logic [31:0]             red_shares;
  logic [31:0]             remain;
  logic                    key_hit;
  logic                    probe_end;
  ort_pkg::result_t        res_act;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign slot_cur   = base_q + IDX_W'(probe_q);

  // second hash pass of a replace starts once its remove is loaded into the output register
  assign hash_start = in_acc || ((state_q == S_OUT) && out_free && !pend_q.last);
  assign hash_key   = (state_q == S_IDLE) ? order_ref_i : nref_q;

  ort_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  ort_table u_table (
    .clk_i       (clk_i),
    .req_i       (tbl_req),
    .rd_status_o (rd_status),
    .rd_entry_o  (rd_entry)
  );

  // probe check
  assign key_hit   = (rd_status == ort_pkg::ST_USED) && (rd_entry.key == key_q);
  assign probe_end = (rd_status == ort_pkg::ST_EMPTY) ||
                     (probe_q == PRB_W'(ort_pkg::MAX_PROBES - 1));

  // update decisions
  assign ins_mode   = (op_q == ort_pkg::OP_ADD) || pass_q;
  assign tgt_vld    = hit_q || free_vld_q;
  assign tgt_slot   = hit_q ? hit_slot_q : free_slot_q;
  assign red_shares = (qty_q < hit_ent_q.shares) ? qty_q : hit_ent_q.shares;
  assign remain     = hit_ent_q.shares - red_shares;

  // table access
  always_comb begin
    tbl_req           = '0;
    tbl_req.rd_addr   = slot_cur;
    tbl_req.st_wdata  = ort_pkg::ST_EMPTY;
    tbl_req.ent_wdata = hit_ent_q;
    case (state_q)
      S_CLEAR: begin
        tbl_req.st_we   = 1'b1;
        tbl_req.wr_addr = clr_cnt_q;
      end
      S_ACT: begin
        if (ins_mode) begin
          tbl_req.wr_addr   = tgt_slot;
          tbl_req.st_we     = tgt_vld;
          tbl_req.ent_we    = tgt_vld;
          tbl_req.st_wdata  = ort_pkg::ST_USED;
          tbl_req.ent_wdata = '{key: key_q, price: price_q, shares: qty_q,
                                instrument: ins_inst_q, side: ins_side_q};
        end else if (hit_q) begin
          tbl_req.wr_addr  = hit_slot_q;
          tbl_req.st_wdata = ort_pkg::ST_TOMB;
          case (op_q)
            ort_pkg::OP_REDUCE: begin
              tbl_req.ent_we           = 1'b1;
              tbl_req.ent_wdata.shares = remain;
              tbl_req.st_we            = (remain == 32'd0);
            end
            ort_pkg::OP_DELETE, ort_pkg::OP_REPLACE: begin
              tbl_req.st_we = 1'b1;
            end
            default: begin
              tbl_req.st_we = 1'b0;
            end
          endcase
        end
      end
      default: begin
        tbl_req.st_we = 1'b0;
      end
    endcase
  end

  // book command of the update cycle
  always_comb begin
    res_act      = '0;
    res_act.kind = ort_pkg::KIND_NONE;
    res_act.last = 1'b1;
    if (ins_mode) begin
      res_act.kind       = ort_pkg::KIND_ADD;
      res_act.book_index = ins_inst_q;
      res_act.price      = price_q;
      res_act.shares     = qty_q;
      res_act.side       = ins_side_q;
      res_act.overflow   = !tgt_vld;
    end else if (hit_q) begin
      res_act.kind       = ort_pkg::KIND_REMOVE;
      res_act.book_index = hit_ent_q.instrument;
      res_act.price      = hit_ent_q.price;
      res_act.side       = hit_ent_q.side;
      case (op_q)
        ort_pkg::OP_REDUCE:  res_act.shares = red_shares;
        ort_pkg::OP_REPLACE: begin
          res_act.shares = hit_ent_q.shares;
          res_act.last   = 1'b0;
        end
        default:             res_act.shares = hit_ent_q.shares;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_cnt_q == IDX_W'(ort_pkg::TABLE_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_HASH;
      S_HASH:  if (hash_done) state_d = S_RD;
      S_RD:    state_d = S_CHK;
      S_CHK:   state_d = (key_hit || probe_end) ? S_ACT : S_RD;
      S_ACT:   state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = pend_q.last ? S_IDLE : S_HASH;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // message and lookup data
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q       <= ort_pkg::opcode_e'(opcode_i);
        key_q      <= order_ref_i;
        nref_q     <= new_ref_i;
        price_q    <= price_i;
        qty_q      <= quantity_i;
        ins_inst_q <= instrument_i;
        ins_side_q <= side_in_i;
        pass_q     <= 1'b0;
      end
      S_HASH: begin
        base_q     <= hash_home;
        probe_q    <= '0;
        hit_q      <= 1'b0;
        free_vld_q <= 1'b0;
      end
      S_CHK: begin
        if (key_hit) begin
          hit_q      <= 1'b1;
          hit_slot_q <= slot_cur;
          hit_ent_q  <= rd_entry;
        end
        if ((rd_status != ort_pkg::ST_USED) && !free_vld_q) begin
          free_vld_q  <= 1'b1;
          free_slot_q <= slot_cur;
        end
        probe_q <= probe_q + PRB_W'(1);
      end
      S_ACT: begin
        pend_q <= res_act;
        // a replace re-adds under the old instrument and side
        if (!ins_mode) begin
          ins_inst_q <= hit_ent_q.instrument;
          ins_side_q <= hit_ent_q.side;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_q <= pend_q;
          if (!pend_q.last) begin
            pass_q <= 1'b1;
            key_q  <= nref_q;
          end
        end
      end
      default: begin
        pass_q <= pass_q;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign book_index_o   = out_q.book_index;
  assign level_price_o  = out_q.price;
  assign level_shares_o = out_q.shares;
  assign side_out_o     = out_q.side;
  assign overflow_o     = out_q.overflow;
  assign last_o         = out_q.last;

  // checks
  `ORT_ASSERT(a_none_is_last, (out_valid_o && (kind_o == ort_pkg::KIND_NONE)) |-> (last_o && (book_index_o == 16'd0)), "unknown reference result must be final and zero")
  `ORT_ASSERT_ALWAYS(a_ovf_on_add, (out_valid_o && overflow_o) |-> (kind_o == ort_pkg::KIND_ADD), "overflow flagged on a non-add result")
  `ORT_ASSERT(a_hash_in_hash, hash_done |-> (state_q == S_HASH), "hash finished outside the hash wait")
  `ORT_ASSERT(a_load_free, ((state_q == S_OUT) && !out_free) |=> (state_q == S_OUT), "result dropped while output held")

endmodule
